@@ hdl/psl_pkg.sv @@
// shared constants and control types for the stop-line crossing block
`default_nettype none
package psl_pkg;

  localparam int DEF_MAX_LINES  = 64;
  localparam int DEF_COORD_BITS = 32;

  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 32;
  localparam int FIELD_W    = 32;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd3;

  typedef struct packed {
    logic clear;
    logic load;
    logic set_prev;
    logic seg_start;
    logic sq_load;
    logic sqrt_start;
    logic scan_start;
    logic scan_issue;
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic emit;
  } psl_cmd_t;

  typedef struct packed {
    logic prev_valid;
    logic scan_more;
    logic pipe_busy;
    logic sqrt_busy;
    logic hit;
    logic out_free;
  } psl_sts_t;

endpackage
`default_nettype wire

@@ hdl/psl_ctrl.sv @@
// sequencer for table commands, line scan, bit-serial multiply and divide
`default_nettype none
module psl_ctrl
  import psl_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] opcode,
  output logic                 in_ready,
  input  wire psl_sts_t        sts,
  output psl_cmd_t             cmd
);

  localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int LW   = CW + 1;
  localparam int CNTW = $clog2(LW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_SQST  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]      st_r, st_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            last;

  assign in_ready = (st_r == S_IDLE);
  assign last     = (cnt_r == CNTW'(LW - 1));

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    cmd     = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD:  cmd.load  = 1'b1;
            OP_FIRST: cmd.set_prev = 1'b1;
            OP_NEXT: begin
              if (sts.prev_valid) begin
                cmd.seg_start = 1'b1;
                st_nxt = S_PREP;
              end else begin
                cmd.set_prev = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd.sq_load = 1'b1;
        st_nxt = S_SQST;
      end
      S_SQST: begin
        cmd.sqrt_start = 1'b1;
        cmd.scan_start = 1'b1;
        st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_more) cmd.scan_issue = 1'b1;
        else st_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy && !sts.sqrt_busy) begin
          if (sts.hit) begin
            cmd.mul_start = 1'b1;
            cnt_nxt = '0;
            st_nxt = S_MUL;
          end else begin
            st_nxt = S_EMIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (last) begin
          cnt_nxt = '0;
          st_nxt = S_DIVI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_start = 1'b1;
        st_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (last) begin
          cnt_nxt = '0;
          st_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/psl_dp.sv @@
// line table, segment registers, scan pipeline, square root, multiply, divide
`default_nettype none
module psl_dp
  import psl_pkg::*;
#(
  parameter int MAX_LINES  = DEF_MAX_LINES,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire psl_cmd_t              cmd,
  output psl_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int CW    = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int CRW   = PW + 1;
  localparam int DENW  = PW + 3;
  localparam int LW    = DW;
  localparam int PRW   = DENW + LW;
  localparam int SRW   = DW + 3;
  localparam int MW    = 4 * CW;
  localparam int CNTW  = $clog2(MAX_LINES + 1);
  localparam int AW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SQCW  = $clog2(LW + 1);

  logic signed [CW-1:0] in_fx, in_fy, in_sx, in_sy;
  assign in_fx = in_data[CW-1:0];
  assign in_fy = in_data[FIELD_W+CW-1:FIELD_W];
  assign in_sx = in_data[2*FIELD_W+CW-1:2*FIELD_W];
  assign in_sy = in_data[3*FIELD_W+CW-1:3*FIELD_W];

  // table and pointer state
  logic [MW-1:0]   mem [MAX_LINES];
  logic [CNTW-1:0] count_r, addr_r;
  logic [MW-1:0]   rd_r;

  logic signed [CW-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                 prev_valid_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [PW-1:0] sqx_r, sqy_r;

  // scan pipeline
  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [DW-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [PW-1:0]  p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [CRW-1:0] c1_r, c2_r, xc_r;
  logic signed [DENW-1:0] den5_r, num5_r;
  logic                  skip5_r;
  logic                  hit_r;
  logic [DENW-1:0]       hnum_r, hden_r;

  // square root, multiply, divide
  logic [PW-1:0]   sq_op_r;
  logic [LW-1:0]   root_r;
  logic [SRW-1:0]  srem_r;
  logic [SQCW-1:0] sq_cnt_r;
  logic [PRW-1:0]  acc_r;
  logic [LW-1:0]   mlen_r;
  logic [DENW-1:0] drem_r;
  logic [LW-1:0]   qsh_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic signed [CW-1:0]   rbx, rby, rfx, rfy;
  logic signed [CRW-1:0]  c1_nxt, c2_nxt, xc_nxt;
  logic signed [DENW-1:0] den_p, den_n, num_p, num_n;
  logic                   c1_pos, c1_neg, c2_pos, c2_neg;
  logic [SRW-1:0]         srs, strial;
  logic                   sge;
  logic [DENW:0]          dt, dsub;
  logic                   dge;
  logic [63:0]            q64;
  logic [30:0]            dist_sat;

  assign {rfy, rfx, rby, rbx} = rd_r;

  assign c1_nxt = CRW'(p0_r) - CRW'(p1_r);
  assign c2_nxt = CRW'(p2_r) - CRW'(p3_r);
  assign xc_nxt = CRW'(p4_r) - CRW'(p5_r);

  assign c1_pos = !c1_r[CRW-1] && (c1_r != '0);
  assign c1_neg = c1_r[CRW-1];
  assign c2_pos = !c2_r[CRW-1] && (c2_r != '0);
  assign c2_neg = c2_r[CRW-1];
  assign den_p  = DENW'(c2_r) - DENW'(c1_r);
  assign den_n  = DENW'(c1_r) - DENW'(c2_r);
  assign num_p  = DENW'(xc_r);
  assign num_n  = -DENW'(xc_r);

  assign srs    = {srem_r[DW:0], sq_op_r[PW-1 -: 2]};
  assign strial = SRW'({root_r, 2'b01});
  assign sge    = (srs >= strial);

  assign dt   = {drem_r, qsh_r[LW-1]};
  assign dsub = dt - {1'b0, hden_r};
  assign dge  = (dt >= {1'b0, hden_r});

  assign q64      = 64'(qsh_r);
  assign dist_sat = (q64 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : q64[30:0];

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNTW'(MAX_LINES)))
      mem[count_r[AW-1:0]] <= {in_sy, in_sx, in_fy, in_fx};
    if (cmd.scan_issue)
      rd_r <= mem[addr_r[AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.set_prev) begin
      prev_x_r <= in_fx;
      prev_y_r <= in_fy;
    end else if (cmd.emit) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (cmd.seg_start) begin
      cur_x_r <= in_fx;
      cur_y_r <= in_fy;
      dx_r    <= DW'(in_fx) - DW'(prev_x_r);
      dy_r    <= DW'(in_fy) - DW'(prev_y_r);
    end
    if (cmd.sq_load) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (cmd.scan_start) addr_r <= '0;
    else if (cmd.scan_issue) addr_r <= addr_r + 1'b1;

    ax_r <= DW'(rbx) - DW'(prev_x_r);
    ay_r <= DW'(rby) - DW'(prev_y_r);
    bx_r <= DW'(rfx) - DW'(prev_x_r);
    by_r <= DW'(rfy) - DW'(prev_y_r);
    p0_r <= dx_r * ay_r;
    p1_r <= dy_r * ax_r;
    p2_r <= dx_r * by_r;
    p3_r <= dy_r * bx_r;
    p4_r <= ax_r * by_r;
    p5_r <= ay_r * bx_r;
    c1_r <= c1_nxt;
    c2_r <= c2_nxt;
    xc_r <= xc_nxt;
    skip5_r <= (c1_pos && c2_pos) || (c1_neg && c2_neg);
    den5_r  <= den_p[DENW-1] ? den_n : den_p;
    num5_r  <= den_p[DENW-1] ? num_n : num_p;
    if (v5_r && !skip5_r && (den5_r != '0) && !num5_r[DENW-1] && (num5_r <= den5_r)) begin
      hnum_r <= num5_r;
      hden_r <= den5_r;
    end

    if (cmd.sqrt_start) begin
      sq_op_r <= PW'(unsigned'(sqx_r)) + PW'(unsigned'(sqy_r));
      root_r  <= '0;
      srem_r  <= '0;
    end else if (sq_cnt_r != '0) begin
      sq_op_r <= {sq_op_r[PW-3:0], 2'b00};
      root_r  <= {root_r[LW-2:0], sge};
      srem_r  <= sge ? (srs - strial) : srs;
    end

    if (cmd.mul_start) begin
      acc_r  <= '0;
      mlen_r <= root_r;
    end else if (cmd.mul_step) begin
      acc_r  <= {acc_r[PRW-2:0], 1'b0} + (mlen_r[LW-1] ? PRW'(hnum_r) : '0);
      mlen_r <= {mlen_r[LW-2:0], 1'b0};
    end

    if (cmd.div_start) begin
      drem_r <= acc_r[PRW-1:LW];
      qsh_r  <= acc_r[LW-1:0];
    end else if (cmd.div_step) begin
      drem_r <= dge ? dsub[DENW-1:0] : dt[DENW-1:0];
      qsh_r  <= {qsh_r[LW-2:0], dge};
    end

    if (cmd.emit) out_data_r <= {(hit_r ? dist_sat : 31'd0), hit_r};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      prev_valid_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      hit_r        <= 1'b0;
      sq_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear) count_r <= '0;
      else if (cmd.load && (count_r < CNTW'(MAX_LINES))) count_r <= count_r + 1'b1;
      if (cmd.set_prev) prev_valid_r <= 1'b1;
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.scan_start) hit_r <= 1'b0;
      else if (v5_r && !skip5_r && (den5_r != '0) && !num5_r[DENW-1] &&
               (num5_r <= den5_r)) hit_r <= 1'b1;
      if (cmd.sqrt_start) sq_cnt_r <= SQCW'(LW);
      else if (sq_cnt_r != '0) sq_cnt_r <= sq_cnt_r - 1'b1;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.prev_valid = prev_valid_r;
  assign sts.scan_more  = (addr_r < count_r);
  assign sts.pipe_busy  = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign sts.sqrt_busy  = (sq_cnt_r != '0);
  assign sts.hit        = hit_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ hdl/path_stop_line_crossing_core.sv @@
// top level of the path stop-line crossing detector
//
// input stream: in_tuser carries the opcode (clear table, load stop line,
// first waypoint of a lane, next waypoint), in_tdata the four coordinates
// in signed Q22.10 metres. one beat is taken at a time; in_tready is high
// only while the sequencer is idle.
// result stream: one beat per next waypoint that closes a segment, with
// the stop flag and the distance from the previous waypoint.
// clear, load and first waypoint beats are handled in the idle state.
// a closing waypoint passes through the prep, root-start, scan, drain and
// emit states; drain waits for the one-line-per-cycle scan pipeline over
// the table memory and the bit-serial square root; a hit adds the
// bit-serial multiply and divide between drain and emit, one bit per
// cycle each.
// reset empties the table and forgets the previous waypoint.
// the result sits in an output register; a stalled receiver holds the
// sequencer only when the next result is ready to be written, so new
// table and waypoint beats are still taken meanwhile.
`default_nettype none
module path_stop_line_crossing_core
  import psl_pkg::*;
#(
  parameter int MAX_LINES  = DEF_MAX_LINES,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // first_x, first_y, second_x, second_y
  input  wire logic [OP_W-1:0]       in_tuser,  // opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata  // stop_flag, stop_distance
);

  psl_cmd_t cmd;
  psl_sts_t sts;

  // sequencer
  psl_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .opcode  (in_tuser),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // table, arithmetic and result register
  psl_dp #(
    .MAX_LINES (MAX_LINES),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_tdata),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

  // no distance without a stop flag
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[31:1] == 31'd0))
    else $error("distance set without stop flag");

  // idle sequencer means scan and root units are quiet
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sts.pipe_busy && !sts.sqrt_busy))
    else $error("scan or root busy while idle");

  // a closing waypoint blocks the input on the next cycle
  a_seg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_NEXT) && sts.prev_valid) |=> !in_tready)
    else $error("segment beat did not start the scan");

endmodule
`default_nettype wire
